[rtl/url_part_locator_macros.svh]
// ---------------------------------------------------------------------------
// url_part_locator_macros.svh
// assertion macros for the url part locator rtl
// ---------------------------------------------------------------------------
`ifndef URL_PART_LOCATOR_MACROS_SVH
`define URL_PART_LOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define UPL_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("url_part_locator: assertion failed");
// next-cycle implication, sampled on clk_i, off during reset
`define UPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("url_part_locator: assertion failed");
`else
`define UPL_ASSERT_HOLD(lbl, ante, cons)
`define UPL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/upl_pkg.sv]
// ---------------------------------------------------------------------------
// upl_pkg
// widths, types and helpers shared by the url part locator
// ---------------------------------------------------------------------------
package upl_pkg;

  // longest stream that is examined, in bytes
  localparam int MAX_URL_BYTES = 4096;

  // byte counter holds 0..MAX_URL_BYTES
  localparam int IDX_W   = $clog2(MAX_URL_BYTES + 1);
  // result field widths
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  // width for offset arithmetic
  localparam int CALC_W  = (IDX_W > LEN_W) ? IDX_W : LEN_W;

  // position marker meaning not seen
  localparam logic [IDX_W-1:0] POS_NONE = '1;

  // part selector codes, other codes are invalid
  typedef enum logic [3:0] {
    PART_AUTHORITY = 4'd0,
    PART_FILE      = 4'd1,
    PART_HOST      = 4'd2,
    PART_PATH      = 4'd3,
    PART_PROTOCOL  = 4'd4,
    PART_QUERY     = 4'd5,
    PART_REF       = 4'd6,
    PART_USERINFO  = 4'd7
  } part_sel_e;

  // one input beat held in the input register
  typedef struct packed {
    logic [7:0] url_byte;
    logic       last_byte;
  } upl_beat_t;

  // per-stream tracking state, also the snapshot at the last byte
  typedef struct packed {
    logic             over_len;
    logic [IDX_W-1:0] trim_pos;
    logic [IDX_W-1:0] nonspace_pos;
    logic [IDX_W-1:0] scheme_pos;
    logic [IDX_W-1:0] slash_pos;
    logic [IDX_W-1:0] quest_pos;
    logic [IDX_W-1:0] hash_pos;
    logic [IDX_W-1:0] at_pos;
    logic [IDX_W-1:0] hash_slash_pos;
    logic [IDX_W-1:0] quest_slash_pos;
    logic [IDX_W-1:0] hash_quest_pos;
    logic [IDX_W-1:0] colon_at_pos;
    logic [IDX_W-1:0] colon_scheme_pos;
  } upl_snap_t;

  localparam upl_snap_t SNAP_CLEAR = '{
    over_len:         1'b0,
    trim_pos:         POS_NONE,
    nonspace_pos:     POS_NONE,
    scheme_pos:       POS_NONE,
    slash_pos:        POS_NONE,
    quest_pos:        POS_NONE,
    hash_pos:         POS_NONE,
    at_pos:           POS_NONE,
    hash_slash_pos:   POS_NONE,
    quest_slash_pos:  POS_NONE,
    hash_quest_pos:   POS_NONE,
    colon_at_pos:     POS_NONE,
    colon_scheme_pos: POS_NONE
  };

  function automatic logic pos_none(input logic [IDX_W-1:0] pos);
    return pos == POS_NONE;
  endfunction

  function automatic logic [CALC_W-1:0] pos_wide(input logic [IDX_W-1:0] pos);
    return CALC_W'(pos);
  endfunction

endpackage

[rtl/upl_byte_if.sv]
// ---------------------------------------------------------------------------
// upl_byte_if
// valid/ready channel carrying one url byte per beat
// ---------------------------------------------------------------------------
interface upl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       last_byte;

  modport source (output valid, output url_byte, output last_byte, input ready);
  modport sink   (input valid, input url_byte, input last_byte, output ready);
endinterface

[rtl/upl_part_if.sv]
// ---------------------------------------------------------------------------
// upl_part_if
// valid/ready channel carrying one located part per beat
// ---------------------------------------------------------------------------
interface upl_part_if import upl_pkg::*;;
  logic               valid;
  logic               ready;
  logic               part_found;
  logic [START_W-1:0] part_start;
  logic [LEN_W-1:0]   part_length;
  logic               too_long;

  modport source (output valid, output part_found, output part_start,
                  output part_length, output too_long, input ready);
  modport sink   (input valid, input part_found, input part_start,
                  input part_length, input too_long, output ready);
endinterface

[rtl/upl_tracker.sv]
// ---------------------------------------------------------------------------
// upl_tracker
// per-byte delimiter tracking and snapshot of the state at the last byte
// ---------------------------------------------------------------------------
module upl_tracker import upl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      beat_valid_i,
  input  upl_beat_t beat_i,
  output logic      beat_take_o,
  input  logic      snap_take_i,
  output logic      snap_valid_o,
  output upl_snap_t snap_o
);

  localparam int IDX1_W = IDX_W + 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AT    = 8'h40;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      prior_q, prior_d;
  upl_snap_t        trk_q, trk_d;
  upl_snap_t        snap_q;
  logic             snap_valid_q;
  logic             beat_fire;
  logic             past_scheme;
  logic [7:0]       c;

  // a last beat waits while the snapshot slot is occupied and not draining
  assign beat_take_o  = !beat_i.last_byte || !snap_valid_q || snap_take_i;
  assign beat_fire    = beat_valid_i && beat_take_o;
  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign c            = beat_i.url_byte;

  // delimiters count only from the byte after "://"
  assign past_scheme = !pos_none(trk_q.scheme_pos) &&
                       (IDX1_W'(idx_q) > (IDX1_W'(trk_q.scheme_pos) + IDX1_W'(2)));

  // next tracking state for the byte in the input register
  always_comb begin
    trk_d   = trk_q;
    idx_d   = idx_q;
    prior_d = prior_q;
    if (idx_q >= IDX_W'(MAX_URL_BYTES)) begin
      trk_d.over_len = 1'b1;
    end else begin
      // trim bounds
      if (c != CH_SPACE) begin
        if (pos_none(trk_q.trim_pos)) trk_d.trim_pos = idx_q;
        trk_d.nonspace_pos = idx_q;
      end
      if (past_scheme) begin
        case (c)
          CH_SLASH: begin
            if (pos_none(trk_q.slash_pos)) trk_d.slash_pos = idx_q;
          end
          CH_QUEST: begin
            if (pos_none(trk_q.quest_pos)) trk_d.quest_pos = idx_q;
            if (!pos_none(trk_q.slash_pos) && pos_none(trk_q.quest_slash_pos))
              trk_d.quest_slash_pos = idx_q;
          end
          CH_HASH: begin
            if (pos_none(trk_q.hash_pos)) trk_d.hash_pos = idx_q;
            if (!pos_none(trk_q.slash_pos) && pos_none(trk_q.hash_slash_pos))
              trk_d.hash_slash_pos = idx_q;
            if (!pos_none(trk_q.quest_pos) && pos_none(trk_q.hash_quest_pos))
              trk_d.hash_quest_pos = idx_q;
          end
          CH_AT: begin
            if (pos_none(trk_q.at_pos)) trk_d.at_pos = idx_q;
          end
          CH_COLON: begin
            if (pos_none(trk_q.colon_scheme_pos)) trk_d.colon_scheme_pos = idx_q;
            if (!pos_none(trk_q.at_pos) && pos_none(trk_q.colon_at_pos))
              trk_d.colon_at_pos = idx_q;
          end
          default: ;
        endcase
      end else if (pos_none(trk_q.scheme_pos) && (c == CH_SLASH) &&
                   (prior_q == {CH_COLON, CH_SLASH})) begin
        // third byte of the first "://", mark its colon
        trk_d.scheme_pos = idx_q - IDX_W'(2);
      end
      prior_d = {prior_q[7:0], c};
      idx_d   = idx_q + IDX_W'(1);
    end
  end

  // tracking state, cleared after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      prior_q <= '0;
      trk_q   <= SNAP_CLEAR;
    end else if (beat_fire) begin
      if (beat_i.last_byte) begin
        idx_q   <= '0;
        prior_q <= '0;
        trk_q   <= SNAP_CLEAR;
      end else begin
        idx_q   <= idx_d;
        prior_q <= prior_d;
        trk_q   <= trk_d;
      end
    end
  end

  // snapshot slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (beat_fire && beat_i.last_byte) begin
      snap_valid_q <= 1'b1;
    end else if (snap_take_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  // snapshot payload
  always_ff @(posedge clk_i) begin
    if (beat_fire && beat_i.last_byte) begin
      snap_q <= trk_d;
    end
  end

endmodule

[rtl/upl_extract.sv]
// ---------------------------------------------------------------------------
// upl_extract
// part selection from a stream snapshot into the result register
// ---------------------------------------------------------------------------
module upl_extract import upl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              snap_valid_i,
  input  upl_snap_t         snap_i,
  output logic              snap_take_o,
  upl_part_if.source        part_o
);

  part_sel_e         part_sel_q;
  logic              out_valid_q;
  logic              found_q;
  logic [START_W-1:0] start_q;
  logic [LEN_W-1:0]  length_q;
  logic              too_long_q;

  logic              aend_none;
  logic [CALC_W-1:0] aend, ae, te, pe;
  logic [CALC_W-1:0] start, endp, diff;
  logic [IDX_W-1:0]  colon;
  logic              found;

  // selector register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_sel_q <= PART_AUTHORITY;
    end else if (cfg_we_i) begin
      part_sel_q <= part_sel_e'(cfg_wdata_i);
    end
  end

  // result register frees when empty or when the beat is taken
  assign snap_take_o = !out_valid_q || part_o.ready;

  // authority bounds
  always_comb begin
    te = pos_wide(snap_i.nonspace_pos) + CALC_W'(1);
    pe = pos_wide(snap_i.scheme_pos) + CALC_W'(3);
    if (pos_none(snap_i.slash_pos) ||
        (!pos_none(snap_i.quest_pos) && (snap_i.quest_pos < snap_i.slash_pos))) begin
      aend_none = pos_none(snap_i.quest_pos);
      aend      = pos_wide(snap_i.quest_pos);
    end else begin
      aend_none = 1'b0;
      aend      = pos_wide(snap_i.slash_pos);
    end
    ae = aend_none ? te : aend;
  end

  // part bounds
  always_comb begin
    found = !snap_i.over_len && !pos_none(snap_i.scheme_pos);
    start = '0;
    endp  = '0;
    colon = POS_NONE;
    unique case (part_sel_q) inside
      PART_AUTHORITY: begin
        start = pe;
        endp  = ae;
      end
      PART_FILE, PART_PATH: begin
        if (!pos_none(snap_i.slash_pos)) begin
          start = pos_wide(snap_i.slash_pos);
          if ((part_sel_q == PART_PATH) && !pos_none(snap_i.quest_slash_pos))
            endp = pos_wide(snap_i.quest_slash_pos);
          else if (!pos_none(snap_i.hash_slash_pos))
            endp = pos_wide(snap_i.hash_slash_pos);
          else
            endp = te;
        end
      end
      PART_HOST: begin
        if (!pos_none(snap_i.at_pos) && (pos_wide(snap_i.at_pos) < ae)) begin
          start = pos_wide(snap_i.at_pos) + CALC_W'(1);
          colon = snap_i.colon_at_pos;
        end else begin
          start = pe;
          colon = snap_i.colon_scheme_pos;
        end
        endp = (!pos_none(colon) && (pos_wide(colon) < ae)) ? pos_wide(colon) : ae;
      end
      PART_PROTOCOL: begin
        start = pos_wide(snap_i.trim_pos);
        endp  = pos_wide(snap_i.scheme_pos);
      end
      PART_QUERY: begin
        if (pos_none(snap_i.quest_pos)) begin
          found = 1'b0;
        end else begin
          start = pos_wide(snap_i.quest_pos) + CALC_W'(1);
          endp  = pos_none(snap_i.hash_quest_pos) ? te : pos_wide(snap_i.hash_quest_pos);
        end
      end
      PART_REF: begin
        if (pos_none(snap_i.hash_pos)) begin
          found = 1'b0;
        end else begin
          start = pos_wide(snap_i.hash_pos) + CALC_W'(1);
          endp  = te;
        end
      end
      PART_USERINFO: begin
        if (pos_none(snap_i.at_pos) || (!aend_none && (pos_wide(snap_i.at_pos) > aend))) begin
          found = 1'b0;
        end else begin
          start = pe;
          endp  = pos_wide(snap_i.at_pos);
        end
      end
      default: found = 1'b0;
    endcase
    // an inverted span is empty
    diff = (endp < start) ? '0 : (endp - start);
  end

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_take_o) begin
      out_valid_q <= snap_valid_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (snap_take_o && snap_valid_i) begin
      found_q    <= found;
      start_q    <= found ? start[START_W-1:0] : '0;
      length_q   <= found ? diff[LEN_W-1:0] : '0;
      too_long_q <= snap_i.over_len;
    end
  end

  assign part_o.valid       = out_valid_q;
  assign part_o.part_found  = found_q;
  assign part_o.part_start  = start_q;
  assign part_o.part_length = length_q;
  assign part_o.too_long    = too_long_q;

endmodule

[rtl/url_part_locator.sv]
// ---------------------------------------------------------------------------
// url_part_locator
// locates one configured part of a url streamed one byte per beat
// ---------------------------------------------------------------------------
// usage
//   byte_if_i carries one url byte per beat; last_byte marks the final byte.
//   part_if_o carries one result beat per url, on its last byte only:
//   found flag, start offset and length of the selected part, too_long flag.
//   cfg_we_i / cfg_wdata_i write the part selector while the block is idle.
// timing
//   one byte is accepted every cycle while the input is not stalled (see
//   stall). a result for the last byte reaches part_if_o through the input
//   register, the tracking state with snapshot and the result register.
// reset
//   all tracking positions go to not seen, the selector goes to authority
//   and both channels are empty.
// stall
//   while a result waits on part_if_o, ordinary bytes keep flowing; a second
//   last byte is held in the snapshot slot, and the next last byte behind it
//   holds the input until the result register drains.
// ---------------------------------------------------------------------------
`include "url_part_locator_macros.svh"

module url_part_locator import upl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  upl_byte_if.sink   byte_if_i,
  upl_part_if.source part_if_o
);

  logic      in_valid_q;
  upl_beat_t in_beat_q;
  logic      beat_take;
  logic      snap_valid;
  logic      snap_take;
  upl_snap_t snap;

  // input register accepts when empty or when the held beat moves on
  assign byte_if_i.ready = !in_valid_q || beat_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_if_i.ready) begin
      in_valid_q <= byte_if_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_if_i.valid && byte_if_i.ready) begin
      in_beat_q.url_byte  <= byte_if_i.url_byte;
      in_beat_q.last_byte <= byte_if_i.last_byte;
    end
  end

  // delimiter tracking
  upl_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (in_valid_q),
    .beat_i       (in_beat_q),
    .beat_take_o  (beat_take),
    .snap_take_i  (snap_take),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  // part selection and result register
  upl_extract u_extract (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_take_o  (snap_take),
    .part_o       (part_if_o)
  );

  // a snapshot that moves on shows up as a result beat next cycle
  `UPL_ASSERT_NEXT(a_snap_to_result, snap_valid && snap_take, part_if_o.valid)
  // an overlong url never reports a part
  `UPL_ASSERT_HOLD(a_long_not_found, part_if_o.valid && part_if_o.too_long, !part_if_o.part_found)
  // a missing part reports zero offsets
  `UPL_ASSERT_HOLD(a_missing_zero, part_if_o.valid && !part_if_o.part_found, (part_if_o.part_start == '0) && (part_if_o.part_length == '0))

endmodule
